// ===== design/frequency_ordered_lookup_list_assert.svh =====
// Assertion macros for the frequency-ordered lookup list.
// Used by the top level only; no other dependencies.
`ifndef FREQUENCY_ORDERED_LOOKUP_LIST_ASSERT_SVH
`define FREQUENCY_ORDERED_LOOKUP_LIST_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FOLL_ASSERT_IMP(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Implication checked in the cycle after the condition.
`define FOLL_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/foll_pkg.sv =====
// Package for the frequency-ordered lookup list: sizes, opcodes, cell types.
// No dependencies.
`default_nettype none
package foll_pkg;
    localparam int TableDepth = 64;
    localparam int PosW = 6;
    localparam int LenW = 7;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOCATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] count;
        logic [31:0] stamp;
    } entry_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic        shift_all;  // insert: every cell takes its left neighbor
        logic        move;       // locate: cells in (dst, hit] shift, dst loads new
        logic [IdxW-1:0] dst;
        logic [IdxW-1:0] hit;
        entry_t      new_entry;
    } cell_cmd_t;
endpackage
`default_nettype wire

// ===== design/foll_cell.sv =====
// One table cell: holds an entry, compares against the search key and
// against the moving entry's rank. Depends on foll_pkg.
`default_nettype none
module foll_cell (
    input  wire                     aclk,
    input  wire  [foll_pkg::IdxW-1:0] index,
    input  wire  [31:0]             search_key,
    input  wire  [31:0]             rank_count,
    input  wire  [31:0]             rank_stamp,
    input  foll_pkg::cell_cmd_t     cmd,
    input  foll_pkg::entry_t        left_entry,
    output foll_pkg::entry_t        entry,
    output logic                    key_match,
    output logic                    stays_ahead,
    output logic                    equal_later
);
    import foll_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   smaller;

    assign entry     = entry_reg;
    assign key_match = (entry_reg.key == search_key);
    // Entry stays ahead of a moving entry unless smaller count or equal with later stamp.
    assign smaller     = (entry_reg.count < rank_count);
    assign equal_later = (entry_reg.count == rank_count) && (entry_reg.stamp > rank_stamp);
    assign stays_ahead = !(smaller || equal_later);

    // Load from left neighbor, from the moving entry, or hold.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.shift_all) begin
            entry_next = left_entry;
        end else if (cmd.move) begin
            if (index == cmd.dst) begin
                entry_next = cmd.new_entry;
            end else if (index > cmd.dst && index <= cmd.hit) begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end
endmodule
`default_nettype wire

// ===== design/foll_ctrl.sv =====
// Controller: decodes requests, runs the compare and move cycles, holds the
// result register. Depends on foll_pkg.
`default_nettype none
module foll_ctrl (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  [1:0]                  s_opcode,
    input  wire  [31:0]                 s_key,
    input  wire  [5:0]                  s_position,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic                        m_ok,
    output logic [5:0]                  m_found_position,
    output logic [31:0]                 m_entry_key,
    output logic [31:0]                 m_entry_count,
    output logic [6:0]                  m_length,
    input  foll_pkg::entry_t            cells [foll_pkg::TableDepth],
    input  wire  [foll_pkg::TableDepth-1:0] match_vec,
    input  wire  [foll_pkg::TableDepth-1:0] ahead_vec,
    input  wire  [foll_pkg::TableDepth-1:0] later_vec,
    output logic [31:0]                 search_key,
    output logic [31:0]                 rank_count,
    output logic [31:0]                 rank_stamp,
    output foll_pkg::cell_cmd_t         cmd,
    output logic [foll_pkg::CntW-1:0]   total
);
    import foll_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RANK, ST_MOVE, ST_OUT} state_t;

    state_t          state_reg;
    logic [CntW-1:0] total_reg;
    logic [31:0]     acc_reg;
    logic [31:0]     key_reg;
    logic [IdxW-1:0] hit_reg;
    entry_t          new_reg;
    logic            ok_reg;
    logic [PosW-1:0] fpos_reg;
    logic [31:0]     okey_reg;
    logic [31:0]     ocnt_reg;

    logic [TableDepth-1:0] valid_match;
    logic                  hit_any;
    logic [IdxW-1:0]       hit_idx;
    logic [IdxW-1:0]       dst_idx;
    logic                  stop_any;
    logic [IdxW-1:0]       stop_idx;
    logic                  keep_any;
    logic [IdxW-1:0]       keep_idx;
    logic [31:0]           acc_next;
    logic [31:0]           cnt_inc;
    logic                  accept;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_OUT);
    assign m_ok       = ok_reg;
    assign m_found_position = fpos_reg;
    assign m_entry_key   = okey_reg;
    assign m_entry_count = ocnt_reg;
    assign m_length   = LenW'(total_reg);
    assign total      = total_reg;
    assign search_key = key_reg;
    assign rank_count = new_reg.count;
    assign rank_stamp = new_reg.stamp;
    assign acc_next   = (acc_reg == Sat32) ? acc_reg : acc_reg + 32'd1;

    // Qualify matches by occupancy and pick the first one.
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < TableDepth; i++) begin
            valid_match[i] = match_vec[i] && (CntW'(i) < total_reg);
        end
        for (int i = TableDepth - 1; i >= 0; i--) begin
            if (valid_match[i]) begin
                hit_any = 1'b1;
                hit_idx = IdxW'(i);
            end
        end
    end

    // Destination: skip the run of smaller counts just below the hit, then
    // the run of equal counts with later stamps below that.
    always_comb begin
        stop_any = 1'b0;
        stop_idx = '0;
        keep_any = 1'b0;
        keep_idx = '0;
        for (int i = 0; i < TableDepth; i++) begin
            if ((IdxW'(i) < hit_reg) && (ahead_vec[i] || later_vec[i])) begin
                stop_any = 1'b1;
                stop_idx = IdxW'(i);
            end
        end
        for (int i = 0; i < TableDepth; i++) begin
            if (stop_any && (IdxW'(i) <= stop_idx) && !later_vec[i]) begin
                keep_any = 1'b1;
                keep_idx = IdxW'(i);
            end
        end
        dst_idx = keep_any ? keep_idx + 1'b1 : '0;
    end

    assign cnt_inc = (cells[hit_idx].count == Sat32) ? Sat32 : cells[hit_idx].count + 32'd1;

    always_comb begin
        cmd = '0;
        cmd.hit = hit_reg;
        cmd.new_entry = new_reg;
        cmd.dst = dst_idx;
        if (accept && s_opcode == OP_INSERT && total_reg != CntW'(TableDepth)) begin
            cmd.shift_all = 1'b1;
        end
        if (state_reg == ST_MOVE) begin
            cmd.move = 1'b1;
        end
    end

    // Hold state, counters and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            acc_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        key_reg  <= s_key;
                        ok_reg   <= 1'b0;
                        fpos_reg <= '0;
                        okey_reg <= '0;
                        ocnt_reg <= '0;
                        state_reg <= ST_OUT;
                        unique case (s_opcode)
                            OP_INSERT: begin
                                if (total_reg != CntW'(TableDepth)) begin
                                    total_reg <= total_reg + 1'b1;
                                    ok_reg    <= 1'b1;
                                end
                            end
                            OP_LOCATE: begin
                                acc_reg   <= acc_next;
                                state_reg <= ST_RANK;
                            end
                            OP_READ: begin
                                if (CntW'(s_position) < total_reg &&
                                    32'(s_position) < 32'(TableDepth)) begin
                                    ok_reg   <= 1'b1;
                                    okey_reg <= cells[IdxW'(s_position)].key;
                                    ocnt_reg <= cells[IdxW'(s_position)].count;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RANK: begin
                    if (hit_any) begin
                        hit_reg       <= hit_idx;
                        new_reg.key   <= key_reg;
                        new_reg.count <= cnt_inc;
                        new_reg.stamp <= (cells[hit_idx].stamp == '0) ? acc_reg
                                                                     : cells[hit_idx].stamp;
                        state_reg <= ST_MOVE;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_MOVE: begin
                    ok_reg    <= 1'b1;
                    fpos_reg  <= PosW'(dst_idx);
                    ocnt_reg  <= new_reg.count;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/frequency_ordered_lookup_list.sv =====
// Top level of the frequency-ordered lookup list: row of cells plus controller.
// Depends on foll_pkg, foll_cell, foll_ctrl and the assertion header.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_opcode s_key s_position
//  m_      | out       | m_valid m_ready m_ok m_found_position m_entry_key
//          |           | m_entry_count m_length
//
// Insert, read, unused opcode: accept in the idle state, then the result in the
// output state. Locate hit: accept, parallel compare in all cells (rank state),
// one shift across the row (move state), result. Locate miss: no move state.
// One request is held at a time in the controller.
// aresetn synchronously clears the entry count and access counter; cell
// contents need no reset. A stalled result holds until m_ready.
`default_nettype none
`include "frequency_ordered_lookup_list_assert.svh"
module frequency_ordered_lookup_list (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_opcode,
    input  wire  [31:0] s_key,
    input  wire  [5:0]  s_position,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_ok,
    output logic [5:0]  m_found_position,
    output logic [31:0] m_entry_key,
    output logic [31:0] m_entry_count,
    output logic [6:0]  m_length
);
    import foll_pkg::*;

    entry_t              cells [TableDepth];
    logic [TableDepth-1:0] match_vec;
    logic [TableDepth-1:0] ahead_vec;
    logic [TableDepth-1:0] later_vec;
    logic [31:0]         search_key;
    logic [31:0]         rank_count;
    logic [31:0]         rank_stamp;
    cell_cmd_t           cmd;
    logic [CntW-1:0]     total;
    entry_t              front_entry;

    // New key enters the front cell on insert.
    always_comb begin
        front_entry.key   = s_key;
        front_entry.count = '0;
        front_entry.stamp = '0;
    end

    // Row of cells, each fed by its left neighbor.
    for (genvar i = 0; i < TableDepth; i++) begin : g_cell
        foll_cell u_cell (
            .aclk       (aclk),
            .index      (IdxW'(i)),
            .search_key (search_key),
            .rank_count (rank_count),
            .rank_stamp (rank_stamp),
            .cmd        (cmd),
            .left_entry ((i == 0) ? front_entry : cells[(i == 0) ? 0 : i - 1]),
            .entry      (cells[i]),
            .key_match  (match_vec[i]),
            .stays_ahead(ahead_vec[i]),
            .equal_later(later_vec[i])
        );
    end

    foll_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_key           (s_key),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_found_position(m_found_position),
        .m_entry_key     (m_entry_key),
        .m_entry_count   (m_entry_count),
        .m_length        (m_length),
        .cells           (cells),
        .match_vec       (match_vec),
        .ahead_vec       (ahead_vec),
        .later_vec       (later_vec),
        .search_key      (search_key),
        .rank_count      (rank_count),
        .rank_stamp      (rank_stamp),
        .cmd             (cmd),
        .total           (total)
    );

    `FOLL_ASSERT_IMP(a_len_bound, aclk, aresetn, 1'b1, total <= CntW'(TableDepth), "length overflow")
    `FOLL_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "request taken while result pending")
    `FOLL_ASSERT_NEXT(a_ins_grow, aclk, aresetn, s_valid && s_ready && s_opcode == OP_INSERT && total != CntW'(TableDepth), total == $past(total) + 1'b1 && m_ok, "insert did not grow table")
endmodule
`default_nettype wire
